>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Assert that an antecedent implies a consequent in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

>>> rtl/bua_pkg.sv
// ----------------------------------------------------------------------------
// bua_pkg
// Shared types, constants and codes for the upsample and argmax block.
// ----------------------------------------------------------------------------
package bua_pkg;
    localparam int MAX_WIDTH_DEF   = 64;
    localparam int MAX_HEIGHT_DEF  = 64;
    localparam int MAX_CLASSES_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COL_SCALE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_SCALE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACT_MODE    = 3'd5;

    localparam logic [1:0] ACT_SIGMOID = 2'd1;
    localparam logic       OP_LOAD     = 1'b0;
    localparam logic [7:0] UNLABELED   = 8'd255;
    localparam logic signed [17:0] Q8_8_HALF = 18'sd128;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_READ,
        ST_LERP,
        ST_NEXT,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic start;     // capture request and multiply coordinates
        logic map;       // form corners from the products
        logic rd;        // issue one corner read
        logic lerp_row;  // row interpolations
        logic lerp_col;  // column interpolation and compare
        logic first;     // first channel
        logic finish;    // form category into output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic rd_last;   // fourth corner read issued
        logic ch_last;   // last channel
    } stat_t;
endpackage

>>> rtl/bua_if.sv
// ----------------------------------------------------------------------------
// bua_in_if / bua_out_if
// Valid/ready channels carrying requests and results.
// ----------------------------------------------------------------------------
interface bua_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [5:0]  load_row;
    logic [5:0]  load_col;
    logic [3:0]  load_channel;
    logic signed [15:0] score;
    logic [11:0] out_row;
    logic [11:0] out_col;
    modport source (output valid, operation, load_row, load_col, load_channel,
                    score, out_row, out_col, input ready);
    modport sink (input valid, operation, load_row, load_col, load_channel,
                  score, out_row, out_col, output ready);
endinterface

interface bua_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  category;
    logic [11:0] pixel_row;
    logic [11:0] pixel_col;
    modport source (output valid, category, pixel_row, pixel_col, input ready);
    modport sink (input valid, category, pixel_row, pixel_col, output ready);
endinterface

>>> rtl/bilinear_upsample_argmax_mask_top.sv
// ----------------------------------------------------------------------------
// bilinear_upsample_argmax_mask_top
// Loads class scores and classifies output pixels by bilinear argmax.
// ----------------------------------------------------------------------------
// Load requests are accepted while the sequencer is idle and produce no result.
// A classify request passes through a mapping step, then for each channel
// four store reads through the single read port and two interpolation steps,
// and a final step that forms the result once the result register is free.
// The next request is accepted in the cycle after the result is formed.
// Reset restores the configuration defaults; the score store is not cleared.
module bilinear_upsample_argmax_mask_top #(
    parameter int MAX_WIDTH   = bua_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = bua_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_CLASSES = bua_pkg::MAX_CLASSES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bua_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bua_pkg::CFG_DATA_W-1:0] cfg_data,
    bua_in_if.sink                         req,
    bua_out_if.source                      rsp
);
    import bua_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  ctrl_ready;
    logic  out_valid_reg;
    logic  out_free;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = ctrl_ready;

    // hold result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end
    assign rsp.valid = out_valid_reg;

    bua_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req.valid),
        .req_classify (req.operation != OP_LOAD),
        .out_free     (out_free),
        .stat         (stat),
        .req_ready    (ctrl_ready),
        .cmd          (cmd)
    );

    bua_datapath #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MAX_CLASSES (MAX_CLASSES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .load_we      (req.valid && ctrl_ready && req.operation == OP_LOAD),
        .load_row     (req.load_row),
        .load_col     (req.load_col),
        .load_channel (req.load_channel),
        .score        (req.score),
        .out_row      (req.out_row),
        .out_col      (req.out_col),
        .cmd          (cmd),
        .stat         (stat),
        .category     (rsp.category),
        .pixel_row    (rsp.pixel_row),
        .pixel_col    (rsp.pixel_col)
    );
endmodule

>>> rtl/bua_ctrl.sv
// ----------------------------------------------------------------------------
// bua_ctrl
// Sequencer: maps a classify request, then walks channels reading four corners.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module bua_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_classify,
    input  logic           out_free,
    input  bua_pkg::stat_t stat,
    output logic           req_ready,
    output bua_pkg::cmd_t  cmd
);
    import bua_pkg::*;

    state_t state_reg, state_next;
    logic   first_reg, first_next;

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
        end
    end

    // advance sequence
    always_comb
    begin
        state_next = state_reg;
        first_next = first_reg;
        cmd        = '0;
        cmd.first  = first_reg;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid && req_classify)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_MAP;
                end
            end
            ST_MAP:
            begin
                cmd.map    = 1'b1;
                first_next = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.rd = 1'b1;
                if (stat.rd_last) state_next = ST_LERP;
            end
            ST_LERP:
            begin
                cmd.lerp_row = 1'b1;
                state_next   = ST_NEXT;
            end
            ST_NEXT:
            begin
                cmd.lerp_col = 1'b1;
                first_next   = 1'b0;
                state_next   = stat.ch_last ? ST_OUT : ST_READ;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `ASSERT_NEXT(a_map_after_start, clk, rst_n, cmd.start, state_reg == ST_MAP)
    `ASSERT_IMPLY(a_busy_not_ready, clk, rst_n, state_reg != ST_IDLE, !req_ready)
    `ASSERT_NEXT(a_finish_idle, clk, rst_n, cmd.finish, state_reg == ST_IDLE)
endmodule

>>> rtl/bua_datapath.sv
// ----------------------------------------------------------------------------
// bua_datapath
// Score store, coordinate mapping, bilinear interpolation and running argmax.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module bua_datapath #(
    parameter int MAX_WIDTH   = bua_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = bua_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_CLASSES = bua_pkg::MAX_CLASSES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [bua_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bua_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                         load_we,
    input  logic [5:0]                   load_row,
    input  logic [5:0]                   load_col,
    input  logic [3:0]                   load_channel,
    input  logic signed [15:0]           score,
    input  logic [11:0]                  out_row,
    input  logic [11:0]                  out_col,
    input  bua_pkg::cmd_t                cmd,
    output bua_pkg::stat_t               stat,
    output logic [7:0]                   category,
    output logic [11:0]                  pixel_row,
    output logic [11:0]                  pixel_col
);
    import bua_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int CW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int AW = YW + XW + CW;
    localparam int DEPTH = 2 ** AW;

    // configuration registers
    logic [6:0]  in_width_reg, in_height_reg;
    logic [4:0]  class_count_reg;
    logic [23:0] col_scale_reg, row_scale_reg;
    logic [1:0]  act_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_width_reg    <= 7'd64;
            in_height_reg   <= 7'd64;
            class_count_reg <= 5'd16;
            col_scale_reg   <= 24'd65536;
            row_scale_reg   <= 24'd65536;
            act_reg         <= 2'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IN_WIDTH:    in_width_reg    <= cfg_data[6:0];
                REG_IN_HEIGHT:   in_height_reg   <= cfg_data[6:0];
                REG_CLASS_COUNT: class_count_reg <= cfg_data[4:0];
                REG_COL_SCALE:   col_scale_reg   <= cfg_data;
                REG_ROW_SCALE:   row_scale_reg   <= cfg_data;
                REG_ACT_MODE:    act_reg         <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // clamp sizes into 1..maximum, as last index
    logic [10:0] w_last, h_last;
    logic [8:0]  n_last;
    always_comb
    begin
        w_last = (in_width_reg == 7'd0) ? 11'd0 :
                 ({4'd0, in_width_reg} > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH - 1) :
                 {4'd0, in_width_reg} - 11'd1;
        h_last = (in_height_reg == 7'd0) ? 11'd0 :
                 ({4'd0, in_height_reg} > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT - 1) :
                 {4'd0, in_height_reg} - 11'd1;
        n_last = (class_count_reg == 5'd0) ? 9'd0 :
                 ({4'd0, class_count_reg} > 9'(MAX_CLASSES)) ? 9'(MAX_CLASSES - 1) :
                 {4'd0, class_count_reg} - 9'd1;
    end

    // capture pixel and multiply coordinates by scales
    logic [35:0] prow_reg, pcol_reg;
    logic [11:0] row_reg, col_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            prow_reg <= out_row * row_scale_reg;
            pcol_reg <= out_col * col_scale_reg;
            row_reg  <= out_row;
            col_reg  <= out_col;
        end
    end

    // corners and fractions
    logic [YW-1:0] y0_reg, y1_reg;
    logic [XW-1:0] x0_reg, x1_reg;
    logic [15:0]   ty_reg, tx_reg;
    logic [19:0]   yb, yn, xb, xn;
    always_comb
    begin
        yb = prow_reg[35:16];
        xb = pcol_reg[35:16];
        yn = yb + {19'd0, prow_reg[15:0] != 16'd0};
        xn = xb + {19'd0, pcol_reg[15:0] != 16'd0};
    end
    always_ff @(posedge clk)
    begin
        if (cmd.map)
        begin
            y0_reg <= YW'((yb > {9'd0, h_last}) ? {9'd0, h_last} : yb);
            y1_reg <= YW'((yn > {9'd0, h_last}) ? {9'd0, h_last} : yn);
            x0_reg <= XW'((xb > {9'd0, w_last}) ? {9'd0, w_last} : xb);
            x1_reg <= XW'((xn > {9'd0, w_last}) ? {9'd0, w_last} : xn);
            ty_reg <= prow_reg[15:0];
            tx_reg <= pcol_reg[15:0];
        end
    end

    // score store
    logic signed [15:0] store_mem [DEPTH];
    logic signed [15:0] rd_data_reg;
    logic [AW-1:0]      rd_addr;
    logic [1:0]         corner_reg;
    logic [CW-1:0]      ch_reg;
    logic               rd_vld_reg;
    logic [1:0]         rd_corner_reg;
    logic               load_ok;

    assign load_ok = ({26'd0, load_row} < 32'(MAX_HEIGHT)) &&
                     ({26'd0, load_col} < 32'(MAX_WIDTH)) &&
                     ({28'd0, load_channel} < 32'(MAX_CLASSES));

    always_comb
    begin
        rd_addr = {(corner_reg[1] ? y1_reg : y0_reg),
                   (corner_reg[0] ? x1_reg : x0_reg), ch_reg};
    end

    always_ff @(posedge clk)
    begin
        if (load_we && load_ok)
            store_mem[AW'({load_row[YW-1:0], load_col[XW-1:0], CW'(load_channel)})] <= score;
        rd_data_reg <= store_mem[rd_addr];
    end

    // corner and channel counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_reg    <= 2'd0;
            ch_reg        <= '0;
            rd_vld_reg    <= 1'b0;
            rd_corner_reg <= 2'd0;
        end
        else
        begin
            rd_vld_reg    <= cmd.rd;
            rd_corner_reg <= corner_reg;
            if (cmd.map)
                ch_reg <= '0;
            else if (cmd.lerp_col)
                ch_reg <= ch_reg + CW'(1);
            if (cmd.rd)
                corner_reg <= corner_reg + 2'd1;
        end
    end

    assign stat.rd_last = (corner_reg == 2'd3);
    assign stat.ch_last = ({{(9-CW){1'b0}}, ch_reg} == n_last);

    // collect corners 0 y0x0, 1 y0x1, 2 y1x0; corner 3 y1x1 is still
    // in the read register during the row step
    logic signed [15:0] c00_reg, c01_reg, c10_reg;
    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            unique case (rd_corner_reg)
                2'd0: c00_reg <= rd_data_reg;
                2'd1: c01_reg <= rd_data_reg;
                2'd2: c10_reg <= rd_data_reg;
                default: ;
            endcase
        end
    end

    // lerp step: a + floor((b - a) * t / 65536); arithmetic shift floors
    function automatic logic signed [17:0] lerp(input logic signed [17:0] a,
                                                input logic signed [17:0] b,
                                                input logic [15:0] t);
        logic signed [18:0] d;
        logic signed [35:0] p;
        begin
            d = 19'(b) - 19'(a);
            p = 36'(d) * $signed({20'd0, t});
            lerp = a + 18'(p >>> 16);
        end
    endfunction

    // rows first at each column, registered before the column step
    logic signed [17:0] left_reg, right_reg, best_val_reg;
    logic signed [17:0] v;
    logic [CW-1:0]      best_reg;
    logic [7:0]         cat_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.lerp_row)
        begin
            left_reg  <= lerp(18'(c00_reg), 18'(c10_reg), ty_reg);
            right_reg <= lerp(18'(c01_reg), 18'(rd_data_reg), ty_reg);
        end
    end
    assign v = lerp(left_reg, right_reg, tx_reg);

    // running argmax; lowest index wins ties
    always_ff @(posedge clk)
    begin
        if (cmd.lerp_col && (cmd.first || v > best_val_reg))
        begin
            best_val_reg <= v;
            best_reg     <= ch_reg;
        end
    end

    // category and echo into output register
    logic signed [17:0] cut;
    assign cut = (act_reg == ACT_SIGMOID) ? 18'sd0 : Q8_8_HALF;
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if (n_last == 9'd0)
                cat_reg <= (best_val_reg > cut) ? 8'd0 : UNLABELED;
            else
                cat_reg <= 8'(best_reg);
            pixel_row <= row_reg;
            pixel_col <= col_reg;
        end
    end
    assign category = cat_reg;

    `ASSERT_IMPLY(a_corner_zero_at_lerp, clk, rst_n, cmd.lerp_row, corner_reg == 2'd0)
    `ASSERT_NEXT(a_ch_reset_on_map, clk, rst_n, cmd.map, ch_reg == '0)
    `ASSERT_IMPLY(a_no_read_during_lerp, clk, rst_n, cmd.lerp_col, !cmd.rd)
endmodule
